>>> rtl/core/limit_order_book_matcher_top_macros.svh
// Assertion macros for the order book matcher.
// Used by the top level; no other dependencies.
`ifndef LIMIT_ORDER_BOOK_MATCHER_TOP_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_TOP_MACROS_SVH
`define LOB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LOB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/core/lobm_pkg.sv
// Shared types and constants for the order book matcher.
// No dependencies.
`default_nettype none
package lobm_pkg;
  localparam int unsigned DEF_ORDER_SLOTS = 32;
  localparam int unsigned DEF_PRICE_BITS = 32;
  localparam int unsigned DEF_QTY_BITS = 32;
  localparam int unsigned DEF_ID_BITS = 32;
  localparam int unsigned STAMP_BITS = 32;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_CANCEL = 1'b1;

  typedef enum logic [2:0] {
    EV_ACCEPTED  = 3'd0,
    EV_TRADE     = 3'd1,
    EV_CANCELED  = 3'd2,
    EV_DUPLICATE = 3'd3,
    EV_UNKNOWN   = 3'd4,
    EV_FULL      = 3'd5
  } event_kind_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] ord_id;
    logic        buy_side;
    logic [31:0] limit_price;
    logic [31:0] order_quantity;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] resting_id;
    logic [31:0] event_order_id;
    logic [31:0] trade_price;
    logic [31:0] fill_qty;
    logic        last_event;
  } out_item_t;
endpackage
`default_nettype wire

>>> rtl/core/lobm_scan_cmp.sv
// Compare unit: decides whether a candidate slot crosses the limit and beats the current best.
// Depends on lobm_pkg.
`default_nettype none
module lobm_scan_cmp #(
  parameter int unsigned PRICE_BITS = lobm_pkg::DEF_PRICE_BITS
) (
  input  wire logic                  cand_buy,
  input  wire logic [PRICE_BITS-1:0] cand_price,
  input  wire logic [lobm_pkg::STAMP_BITS-1:0] cand_stamp,
  input  wire logic                  have_best,
  input  wire logic [PRICE_BITS-1:0] best_price,
  input  wire logic [lobm_pkg::STAMP_BITS-1:0] best_stamp,
  input  wire logic                  inc_buy,
  input  wire logic [PRICE_BITS-1:0] limit,
  output logic                       crosses,
  output logic                       better
);
  import lobm_pkg::*;
  always_comb begin
    crosses = (cand_buy != inc_buy) &&
              (inc_buy ? (cand_price <= limit) : (cand_price >= limit));
    if (!have_best) begin
      better = 1'b1;
    end else if (cand_price != best_price) begin
      better = inc_buy ? (cand_price < best_price) : (cand_price > best_price);
    end else begin
      better = cand_stamp < best_stamp;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/limit_order_book_matcher_top.sv
// Sequencing: each scan pass visits one slot per cycle.
// Cancel or duplicate: a single duplicate pass per transaction.
// Submit: a duplicate pass, one best pass per trade plus a final one unless the quantity
// runs out, a free-slot pass if a remainder is left, plus the trade, place and flush states.
// Stamp renumbering adds one pass per live order plus one; output stalls add cycles.
// Reset (rst_n low, synchronous) empties the book, zeroes the stamp counter, drops output.
`default_nettype none
module limit_order_book_matcher_top #(
  parameter int unsigned ORDER_SLOTS = lobm_pkg::DEF_ORDER_SLOTS,
  parameter int unsigned PRICE_BITS  = lobm_pkg::DEF_PRICE_BITS,
  parameter int unsigned QTY_BITS    = lobm_pkg::DEF_QTY_BITS,
  parameter int unsigned ID_BITS     = lobm_pkg::DEF_ID_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lobm_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lobm_pkg::out_item_t     out_data
);
  import lobm_pkg::*;
  `include "limit_order_book_matcher_top_macros.svh"

  localparam int unsigned SW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int unsigned CW = $clog2(ORDER_SLOTS + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(ORDER_SLOTS - 1);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_DUP, S_BEST, S_TRADE, S_FREE, S_REN, S_PLACE, S_FLUSH
  } state_t;

  function automatic out_item_t make_ev(event_kind_t kind, logic [31:0] rid,
                                        logic [31:0] oid, logic [31:0] px,
                                        logic [31:0] q);
    out_item_t ev;
    ev.event_kind     = kind;
    ev.resting_id     = rid;
    ev.event_order_id = oid;
    ev.trade_price    = px;
    ev.fill_qty       = q;
    ev.last_event     = 1'b0;
    return ev;
  endfunction

  state_t state_r;
  logic [ORDER_SLOTS-1:0] live_r;
  logic                   is_buy_m  [ORDER_SLOTS];
  logic [ID_BITS-1:0]     id_m      [ORDER_SLOTS];
  logic [PRICE_BITS-1:0]  price_m   [ORDER_SLOTS];
  logic [QTY_BITS-1:0]    rem_m     [ORDER_SLOTS];
  logic [STAMP_BITS-1:0]  stamp_m   [ORDER_SLOTS];
  logic [STAMP_BITS-1:0]  counter_r;

  // registered read of the slot at idx_r
  logic                  rd_buy_r;
  logic [ID_BITS-1:0]    rd_id_r;
  logic [PRICE_BITS-1:0] rd_price_r;
  logic [QTY_BITS-1:0]   rd_rem_r;
  logic [STAMP_BITS-1:0] rd_stamp_r;
  logic                  rd_live_r;
  logic [SW-1:0]         rd_idx_r;
  logic                  rd_ok_r;

  logic [SW-1:0]         idx_r;
  logic                  scan_done_r;
  logic                  cancel_r, buy_r;
  logic [ID_BITS-1:0]    oid_r;
  logic [PRICE_BITS-1:0] lim_r;
  logic [QTY_BITS-1:0]   qty_r;
  logic                  have_best_r, found_r;
  logic [SW-1:0]         best_idx_r;
  logic [SW-1:0]         free_idx_r;
  logic [PRICE_BITS-1:0] best_price_r;
  logic [STAMP_BITS-1:0] best_stamp_r;
  logic [ID_BITS-1:0]    best_id_r;
  logic [QTY_BITS-1:0]   best_rem_r;
  logic [ORDER_SLOTS-1:0] done_r;
  logic [CW-1:0]         rank_r;
  out_item_t             pend_r;

  logic crosses, better;
  lobm_scan_cmp #(.PRICE_BITS(PRICE_BITS)) u_cmp (
    .cand_buy   (rd_buy_r),
    .cand_price (rd_price_r),
    .cand_stamp (rd_stamp_r),
    .have_best  (have_best_r),
    .best_price (best_price_r),
    .best_stamp (best_stamp_r),
    .inc_buy    (buy_r),
    .limit      (lim_r),
    .crosses    (crosses),
    .better     (better)
  );

  // renumber pass: oldest live slot not yet ranked
  logic ren_better;
  assign ren_better = !have_best_r || (rd_stamp_r < best_stamp_r);

  logic [QTY_BITS-1:0] trade_q;
  assign trade_q = (qty_r < best_rem_r) ? qty_r : best_rem_r;

  logic scan_issue, scan_end, out_free;
  assign scan_issue = (state_r inside {S_DUP, S_BEST, S_FREE, S_REN}) && !scan_done_r;
  assign scan_end   = scan_done_r && !rd_ok_r;
  assign out_free   = !out_valid || out_ready;

  assign in_ready = (state_r == S_IDLE);

  // the held result goes out once the next one is known; the last one is flagged
  logic      emit_go, emit_last;
  out_item_t emit_item;
  always_comb begin
    emit_go   = 1'b0;
    emit_last = 1'b0;
    case (state_r)
      S_TRADE: emit_go = out_free;
      S_FREE:  emit_go = out_free && scan_end && !found_r;
      S_FLUSH: begin
        emit_go   = out_free;
        emit_last = 1'b1;
      end
      default: emit_go = 1'b0;
    endcase
    emit_item = pend_r;
    emit_item.last_event = emit_last;
  end

  always_ff @(posedge clk) begin
    rd_buy_r   <= is_buy_m[idx_r];
    rd_id_r    <= id_m[idx_r];
    rd_price_r <= price_m[idx_r];
    rd_rem_r   <= rem_m[idx_r];
    rd_stamp_r <= stamp_m[idx_r];
    rd_idx_r   <= idx_r;
    rd_live_r  <= live_r[idx_r] && !done_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
    end else begin
      rd_ok_r <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      live_r    <= '0;
      done_r    <= '0;
      counter_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
        out_data  <= emit_item;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (scan_issue) begin
        if (idx_r == LAST_SLOT) scan_done_r <= 1'b1;
        else idx_r <= idx_r + SW'(1);
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cancel_r    <= (in_data.opcode == OP_CANCEL);
            oid_r       <= ID_BITS'(in_data.ord_id);
            buy_r       <= in_data.buy_side;
            lim_r       <= PRICE_BITS'(in_data.limit_price);
            qty_r       <= QTY_BITS'(in_data.order_quantity);
            idx_r       <= '0;
            scan_done_r <= 1'b0;
            found_r     <= 1'b0;
            state_r     <= S_DUP;
          end
        end
        S_DUP: begin
          if (rd_ok_r && rd_live_r && rd_id_r == oid_r && !found_r) begin
            found_r    <= 1'b1;
            best_idx_r <= rd_idx_r;
          end
          if (scan_end) begin
            if (cancel_r) begin
              if (found_r) begin
                pend_r <= make_ev(EV_CANCELED, '0, 32'(oid_r), '0, '0);
                live_r[best_idx_r] <= 1'b0;
              end else begin
                pend_r <= make_ev(EV_UNKNOWN, '0, 32'(oid_r), '0, '0);
              end
              state_r <= S_FLUSH;
            end else if (found_r) begin
              pend_r  <= make_ev(EV_DUPLICATE, '0, 32'(oid_r), '0, '0);
              state_r <= S_FLUSH;
            end else begin
              pend_r <= make_ev(EV_ACCEPTED, '0, 32'(oid_r), '0, '0);
              if (qty_r == '0) begin
                state_r <= S_FLUSH;
              end else begin
                idx_r       <= '0;
                scan_done_r <= 1'b0;
                have_best_r <= 1'b0;
                state_r     <= S_BEST;
              end
            end
          end
        end
        S_BEST: begin
          if (rd_ok_r && rd_live_r && crosses && better) begin
            have_best_r  <= 1'b1;
            best_idx_r   <= rd_idx_r;
            best_price_r <= rd_price_r;
            best_stamp_r <= rd_stamp_r;
            best_id_r    <= rd_id_r;
            best_rem_r   <= rd_rem_r;
          end
          if (scan_end) begin
            idx_r       <= '0;
            scan_done_r <= 1'b0;
            if (have_best_r) begin
              state_r <= S_TRADE;
            end else begin
              found_r <= 1'b0;
              state_r <= S_FREE;
            end
          end
        end
        S_TRADE: begin
          if (emit_go) begin
            pend_r <= make_ev(EV_TRADE, 32'(best_id_r), 32'(oid_r),
                              32'(best_price_r), 32'(trade_q));
            rem_m[best_idx_r] <= best_rem_r - trade_q;
            if (best_rem_r == trade_q) live_r[best_idx_r] <= 1'b0;
            qty_r <= qty_r - trade_q;
            if (qty_r == trade_q) begin
              state_r <= S_FLUSH;
            end else begin
              idx_r       <= '0;
              scan_done_r <= 1'b0;
              have_best_r <= 1'b0;
              state_r     <= S_BEST;
            end
          end
        end
        S_FREE: begin
          if (rd_ok_r && !rd_live_r && !found_r) begin
            found_r    <= 1'b1;
            free_idx_r <= rd_idx_r;
          end
          if (scan_end) begin
            if (!found_r) begin
              if (emit_go) begin
                pend_r  <= make_ev(EV_FULL, '0, 32'(oid_r), '0, '0);
                state_r <= S_FLUSH;
              end
            end else if (counter_r == STAMP_MAX) begin
              rank_r      <= '0;
              idx_r       <= '0;
              scan_done_r <= 1'b0;
              have_best_r <= 1'b0;
              state_r     <= S_REN;
            end else begin
              state_r <= S_PLACE;
            end
          end
        end
        S_REN: begin
          if (rd_ok_r && rd_live_r && ren_better) begin
            have_best_r  <= 1'b1;
            best_idx_r   <= rd_idx_r;
            best_stamp_r <= rd_stamp_r;
          end
          if (scan_end) begin
            if (have_best_r) begin
              stamp_m[best_idx_r] <= STAMP_BITS'(rank_r);
              done_r[best_idx_r]  <= 1'b1;
              rank_r      <= rank_r + CW'(1);
              idx_r       <= '0;
              scan_done_r <= 1'b0;
              have_best_r <= 1'b0;
            end else begin
              counter_r <= STAMP_BITS'(rank_r);
              done_r    <= '0;
              state_r   <= S_PLACE;
            end
          end
        end
        S_PLACE: begin
          live_r[free_idx_r]   <= 1'b1;
          is_buy_m[free_idx_r] <= buy_r;
          id_m[free_idx_r]     <= oid_r;
          price_m[free_idx_r]  <= lim_r;
          rem_m[free_idx_r]    <= qty_r;
          stamp_m[free_idx_r]  <= counter_r;
          counter_r            <= counter_r + STAMP_BITS'(1);
          state_r              <= S_FLUSH;
        end
        S_FLUSH: begin
          if (emit_go) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `LOB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `LOB_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE, "input ready outside idle")
  `LOB_ASSERT_NEXT(a_accept_scan, clk, rst_n, in_valid && in_ready, state_r == S_DUP, "accepted transaction did not start a scan")
  `LOB_ASSERT_IMPL(a_trade_best, clk, rst_n, state_r == S_TRADE, have_best_r && qty_r != '0, "trade without a crossing order")
endmodule
`default_nettype wire

>>> sim/limit_order_book_matcher_top_tb.sv
// Self-checking testbench for the limit order book matcher: submits and cancels
// are predicted by an in-bench price-time priority book model and compared per field.
// Depends on lobm_pkg and limit_order_book_matcher_top.
`default_nettype none
module limit_order_book_matcher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lobm_pkg::*;

  localparam int SLOTS = 32;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  limit_order_book_matcher_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // book model
  bit          bk_live [SLOTS];
  bit          bk_buy  [SLOTS];
  logic [31:0] bk_id   [SLOTS];
  logic [31:0] bk_px   [SLOTS];
  logic [31:0] bk_qty  [SLOTS];
  logic [31:0] bk_stamp[SLOTS];
  logic [31:0] stamp_ctr;

  in_item_t  pending_cmds[$];
  out_item_t expected_events[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  recv_hold = 0;
  bit  hold_req = 0;
  bit  send_hold = 0;

  function automatic int find_order(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (bk_live[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int best_opposite(bit buy, logic [31:0] lim);
    int b;
    b = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!bk_live[i] || bk_buy[i] == buy) continue;
      if (buy ? (bk_px[i] > lim) : (bk_px[i] < lim)) continue;
      if (b < 0) b = i;
      else if (bk_px[i] != bk_px[b]) begin
        if (buy ? (bk_px[i] < bk_px[b]) : (bk_px[i] > bk_px[b])) b = i;
      end else if (bk_stamp[i] < bk_stamp[b]) b = i;
    end
    return b;
  endfunction

  function automatic void push_event(event_kind_t k, logic [31:0] rid, logic [31:0] oid,
                                     logic [31:0] px, logic [31:0] q);
    out_item_t e;
    e.event_kind = k;
    e.resting_id = rid;
    e.event_order_id = oid;
    e.trade_price = px;
    e.fill_qty = q;
    e.last_event = 1'b0;
    expected_events.insert(expected_events.size(), e);
  endfunction

  function automatic void renumber_ages();
    bit done[SLOTS];
    int pick;
    logic [31:0] rank;
    rank = 0;
    foreach (done[i]) done[i] = 0;
    forever begin
      pick = -1;
      for (int i = 0; i < SLOTS; i++)
        if (bk_live[i] && !done[i] && (pick < 0 || bk_stamp[i] < bk_stamp[pick])) pick = i;
      if (pick < 0) break;
      done[pick] = 1;
      bk_stamp[pick] = rank;
      rank++;
    end
    stamp_ctr = rank;
  endfunction

  function automatic void match_command(in_item_t c);
    int s;
    int fr;
    logic [31:0] q;
    logic [31:0] left;
    out_item_t e;
    left = c.order_quantity;
    if (c.opcode == OP_CANCEL) begin
      s = find_order(c.ord_id);
      if (s < 0) push_event(EV_UNKNOWN, 0, c.ord_id, 0, 0);
      else begin
        bk_live[s] = 0;
        push_event(EV_CANCELED, 0, c.ord_id, 0, 0);
      end
    end else if (find_order(c.ord_id) >= 0) begin
      push_event(EV_DUPLICATE, 0, c.ord_id, 0, 0);
    end else begin
      push_event(EV_ACCEPTED, 0, c.ord_id, 0, 0);
      while (left > 0) begin
        s = best_opposite(c.buy_side, c.limit_price);
        if (s < 0) break;
        q = (left < bk_qty[s]) ? left : bk_qty[s];
        push_event(EV_TRADE, bk_id[s], c.ord_id, bk_px[s], q);
        left -= q;
        bk_qty[s] -= q;
        if (bk_qty[s] == 0) bk_live[s] = 0;
      end
      if (left > 0) begin
        fr = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!bk_live[i]) begin
            fr = i;
            break;
          end
        if (fr < 0) push_event(EV_FULL, 0, c.ord_id, 0, 0);
        else begin
          if (stamp_ctr == 32'hFFFF_FFFF) renumber_ages();
          bk_live[fr] = 1;
          bk_buy[fr] = c.buy_side;
          bk_id[fr] = c.ord_id;
          bk_px[fr] = c.limit_price;
          bk_qty[fr] = left;
          bk_stamp[fr] = stamp_ctr;
          stamp_ctr++;
        end
      end
    end
    e = expected_events[expected_events.size() - 1];
    e.last_event = 1'b1;
    expected_events[expected_events.size() - 1] = e;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
    end else if (pending_cmds.size() > 0 && !send_hold &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data <= pending_cmds[0];
      pending_cmds.delete(0);
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk)
    if (rst_n && in_valid && in_ready) match_command(in_data);

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t unexpected event: actual %p", $time, out_data);
        end else begin
          e = expected_events[0];
          expected_events.delete(0);
          if (out_data.event_kind !== e.event_kind || out_data.resting_id !== e.resting_id ||
              out_data.event_order_id !== e.event_order_id ||
              out_data.trade_price !== e.trade_price ||
              out_data.fill_qty !== e.fill_qty ||
              out_data.last_event !== e.last_event) begin
            errors++;
            $display("%0t mismatch: expected %p actual %p", $time, e, out_data);
          end
        end
      end
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold, counted here
  initial begin
    forever begin
      wait (hold_req);
      recv_hold = 1;
      repeat (600) @(posedge clk);
      recv_hold = 0;
      hold_req = 0;
    end
  end

  function automatic in_item_t make_cmd(bit op, logic [31:0] id, bit buy,
                                        logic [31:0] px, logic [31:0] q);
    in_item_t c;
    c.opcode = op;
    c.ord_id = id;
    c.buy_side = buy;
    c.limit_price = px;
    c.order_quantity = q;
    return c;
  endfunction

  // random ids drawn from a small pool so duplicates and cancels hit live orders
  function automatic in_item_t random_cmd();
    in_item_t c;
    int r;
    r = $urandom_range(99);
    c.ord_id = (r < 3) ? $urandom() : $urandom_range(60);
    c.buy_side = $urandom_range(1);
    c.limit_price = (r < 6) ? $urandom() : 32'd1000 + $urandom_range(12);
    c.order_quantity = (r < 6) ? $urandom() : (r < 9 ? 0 : $urandom_range(1, 40));
    c.opcode = ($urandom_range(99) < 20) ? OP_CANCEL : OP_SUBMIT;
    if (c.opcode == OP_CANCEL && $urandom_range(1)) begin
      c.buy_side = $urandom_range(1);
      c.limit_price = $urandom();
      c.order_quantity = $urandom();
    end
    return c;
  endfunction

  task automatic add_cmd(in_item_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_cmds.size() > 0 || in_valid || expected_events.size() > 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) add_cmd(random_cmd());
    wait_drained();
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    foreach (bk_live[i]) bk_live[i] = 0;
    stamp_ctr = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    // directed
    add_cmd(make_cmd(OP_CANCEL, 32'd7, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_cmd(make_cmd(OP_SUBMIT, 32'd0, 0, 32'd100, 32'd10));
    add_cmd(make_cmd(OP_SUBMIT, 32'hFFFF_FFFF, 0, 32'd100, 32'd5));
    add_cmd(make_cmd(OP_SUBMIT, 32'd0, 1, 32'd1, 32'd1));
    add_cmd(make_cmd(OP_SUBMIT, 32'd3, 0, 32'd90, 32'd4));
    add_cmd(make_cmd(OP_SUBMIT, 32'd4, 1, 32'hFFFF_FFFF, 32'd16));
    add_cmd(make_cmd(OP_SUBMIT, 32'd5, 1, 32'd50, 32'd0));
    add_cmd(make_cmd(OP_SUBMIT, 32'd6, 1, 32'd0, 32'hFFFF_FFFF));
    add_cmd(make_cmd(OP_SUBMIT, 32'd8, 0, 32'd0, 32'hFFFF_FFFF));
    add_cmd(make_cmd(OP_CANCEL, 32'd4, 0, 0, 0));
    add_cmd(make_cmd(OP_CANCEL, 32'd4, 0, 0, 0));
    for (int i = 0; i < 33; i++)
      add_cmd(make_cmd(OP_SUBMIT, 32'd100 + i, 1, 32'd10 + i % 3, 32'd2));
    add_cmd(make_cmd(OP_SUBMIT, 32'd200, 0, 32'd0, 32'hFFFF_FFFF));
    wait_drained();
    // long receiver hold while commands keep coming
    hold_req = 1;
    repeat (40) add_cmd(random_cmd());
    wait (!hold_req);
    wait_drained();
    run_phase(70, 0, 0);
    run_phase(70, 72, 0);
    run_phase(70, 0, 72);
    send_hold = 1;
    repeat (20) add_cmd(random_cmd());
    repeat (30) @(posedge clk);
    send_hold = 0;
    send_idle_pct = 23;
    recv_stall_pct = 23;
    wait_drained();
    run_phase(60, 23, 23);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/lobm_pkg.sv
rtl/core/lobm_scan_cmp.sv
rtl/core/limit_order_book_matcher_top.sv
sim/limit_order_book_matcher_top_tb.sv
